// ----- hdl/rog_pkg.sv -----
`default_nettype none
package rog_pkg;

	// configuration port
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_XY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd7;

	// rejection causes
	localparam logic [1:0] CAUSE_KEEP   = 2'd0;
	localparam logic [1:0] CAUSE_BEHIND = 2'd1;
	localparam logic [1:0] CAUSE_FAR    = 2'd2;

	// divider: quotient bits developed, clamped prediction magnitude
	localparam int QUO_BITS  = 36;
	localparam int PRED_BITS = 35;
	localparam logic [PRED_BITS-1:0] PRED_LIMIT = 35'h4_0000_0000;

	// residual: clamped differences span -2^28..2^28
	localparam int RES_W = 48;
	localparam logic [RES_W-1:0] RES_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int DIFF_W = 30;

endpackage
`default_nettype wire

// ----- hdl/reprojection_outlier_gate.sv -----
// Channel   Ports                                             Handshake
// input     cam_select point_x point_y point_z obs_u obs_v    start && !busy
// result    reject cause residual_sq                          done, one cycle
// config    cfg_index cfg_data                                cfg_we
//
// One observation enters every cycle; busy stays low.
// The pipeline has 8 arithmetic stages plus 37 stages of the two
// restoring dividers, which develop one quotient bit per stage.
// arst_n clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module reprojection_outlier_gate #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              cam_select,
	input  wire logic signed [31:0]                point_x,
	input  wire logic signed [31:0]                point_y,
	input  wire logic signed [31:0]                point_z,
	input  wire logic signed [31:0]                obs_u,
	input  wire logic signed [31:0]                obs_v,
	output logic                                   done,
	output logic                                   reject,
	output logic [1:0]                             cause,
	output logic [rog_pkg::RES_W-1:0]              residual_sq,
	input  wire logic                              cfg_we,
	input  wire logic [rog_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rog_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rog_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int NW  = 32 + CW;
	localparam int LO  = 16;
	localparam int SIDE_U = 33;
	localparam int SIDE_V = 34;
	localparam int LATENCY = 8 + QUO_BITS + 1;
	localparam logic signed [63:0] PMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
	localparam logic signed [63:0] PMIN = -PMAX - 64'sd1;
	localparam logic signed [39:0] DLIM = 40'sd268435456;

	function automatic logic [CW-1:0] sat_coord(input logic signed [63:0] v);
		logic [CW-1:0] r;
		if (v > PMAX) begin
			r = PMAX[CW-1:0];
		end else if (v < PMIN) begin
			r = PMIN[CW-1:0];
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	// configuration registers
	logic [59:0] rot_q [0:2];
	logic [63:0] center_xy_q;
	logic [31:0] center_z_q;
	logic [63:0] focal_q;
	logic [63:0] principal_q;
	logic [RES_W-1:0] thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]    <= '0;
			rot_q[1]    <= '0;
			rot_q[2]    <= '0;
			center_xy_q <= '0;
			center_z_q  <= '0;
			focal_q     <= '0;
			principal_q <= '0;
			thresh_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT_ROW0:  rot_q[0]    <= cfg_data[59:0];
				REG_ROT_ROW1:  rot_q[1]    <= cfg_data[59:0];
				REG_ROT_ROW2:  rot_q[2]    <= cfg_data[59:0];
				REG_CENTER_XY: center_xy_q <= cfg_data;
				REG_CENTER_Z:  center_z_q  <= cfg_data[31:0];
				REG_FOCAL:     focal_q     <= cfg_data;
				REG_PRINCIPAL: principal_q <= cfg_data;
				REG_THRESH:    thresh_q    <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: capture the transaction, offset by the camera centre
	logic               valid_s1, cam_s1;
	logic signed [31:0] pt_s1 [0:2];
	logic signed [32:0] d_s1  [0:2];
	logic signed [31:0] ou_s1, ov_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cam_s1   <= cam_select;
		pt_s1[0] <= point_x;
		pt_s1[1] <= point_y;
		pt_s1[2] <= point_z;
		d_s1[0]  <= 33'(point_x) - 33'($signed(center_xy_q[31:0]));
		d_s1[1]  <= 33'(point_y) - 33'($signed(center_xy_q[63:32]));
		d_s1[2]  <= 33'(point_z) - 33'($signed(center_z_q));
		ou_s1    <= obs_u;
		ov_s1    <= obs_v;
	end

	// stage 2: nine rotation products
	logic               valid_s2, cam_s2;
	logic signed [31:0] pt_s2 [0:2];
	logic signed [52:0] prod_s2 [0:8];
	logic signed [31:0] ou_s2, ov_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			always_ff @(posedge clk) begin
				prod_s2[3*i+k] <= $signed(rot_q[i][20*k +: 20]) * d_s1[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		cam_s2 <= cam_s1;
		pt_s2  <= pt_s1;
		ou_s2  <= ou_s1;
		ov_s2  <= ov_s1;
	end

	// stage 3: row sums, round half up, saturate; with cam_select low the point passes through unrotated
	logic                 valid_s3;
	logic signed [CW-1:0] p_s3 [0:2];
	logic signed [31:0]   ou_s3, ov_s3;
	logic signed [63:0]   rnd [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = (64'(prod_s2[3*i]) + 64'(prod_s2[3*i+1]) + 64'(prod_s2[3*i+2])
				+ 64'sd131072) >>> 18;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cam_s2) begin
				p_s3[i] <= sat_coord(rnd[i]);
			end else begin
				p_s3[i] <= sat_coord(64'(pt_s2[i]));
			end
		end
		ou_s3 <= ou_s2;
		ov_s3 <= ov_s2;
	end

	// stage 4: depth test, partial products of focal length and magnitude
	logic               valid_s4, behind_s4, neg_u_s4, neg_v_s4;
	logic [47:0]        a_u_s4, a_v_s4;
	logic [CW+15:0]     b_u_s4, b_v_s4;
	logic [CW-1:0]      den_s4;
	logic signed [31:0] ou_s4, ov_s4;
	logic [CW-1:0]      mag_x, mag_y;

	assign mag_x = p_s3[0][CW-1] ? CW'(-p_s3[0]) : p_s3[0];
	assign mag_y = p_s3[1][CW-1] ? CW'(-p_s3[1]) : p_s3[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		behind_s4 <= p_s3[2] <= 0;
		neg_u_s4  <= p_s3[0][CW-1];
		neg_v_s4  <= p_s3[1][CW-1];
		a_u_s4    <= focal_q[31:0] * mag_x[LO-1:0];
		a_v_s4    <= focal_q[63:32] * mag_y[LO-1:0];
		b_u_s4    <= focal_q[31:0] * mag_x[CW-1:LO];
		b_v_s4    <= focal_q[63:32] * mag_y[CW-1:LO];
		den_s4    <= p_s3[2];
		ou_s4     <= ou_s3;
		ov_s4     <= ov_s3;
	end

	// stage 5: assemble the numerators
	logic               valid_s5, behind_s5, neg_u_s5, neg_v_s5;
	logic [NW-1:0]      num_u_s5, num_v_s5;
	logic [CW-1:0]      den_s5;
	logic signed [31:0] ou_s5, ov_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		behind_s5 <= behind_s4;
		neg_u_s5  <= neg_u_s4;
		neg_v_s5  <= neg_v_s4;
		num_u_s5  <= NW'(a_u_s4) + (NW'(b_u_s4) << LO);
		num_v_s5  <= NW'(a_v_s4) + (NW'(b_v_s4) << LO);
		den_s5    <= den_s4;
		ou_s5     <= ou_s4;
		ov_s5     <= ov_s4;
	end

	// dividers
	logic                 div_u_valid, div_v_valid;
	logic [PRED_BITS-1:0] quo_u, quo_v;
	logic [SIDE_U-1:0]    side_u;
	logic [SIDE_V-1:0]    side_v;

	rog_div #(.NW(NW), .DW(CW), .SW(SIDE_U)) u_div_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s5),
		.num      (num_u_s5),
		.den      (den_s5),
		.side     ({neg_u_s5, ou_s5}),
		.out_valid(div_u_valid),
		.quo      (quo_u),
		.out_side (side_u)
	);

	rog_div #(.NW(NW), .DW(CW), .SW(SIDE_V)) u_div_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s5),
		.num      (num_v_s5),
		.den      (den_s5),
		.side     ({behind_s5, neg_v_s5, ov_s5}),
		.out_valid(div_v_valid),
		.quo      (quo_v),
		.out_side (side_v)
	);

	// stage 6: prediction, difference, clamp
	logic                     valid_s6, behind_s6;
	logic signed [DIFF_W-1:0] du_s6, dv_s6;
	logic signed [39:0]       diff_u, diff_v, pq_u, pq_v;

	assign pq_u   = side_u[32] ? 40'(quo_u) : -40'(quo_u);
	assign pq_v   = side_v[32] ? 40'(quo_v) : -40'(quo_v);
	assign diff_u = 40'(signed'(side_u[31:0])) - 40'(principal_q[31:0]) + pq_u;
	assign diff_v = 40'(signed'(side_v[31:0])) - 40'(principal_q[63:32]) + pq_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= div_u_valid;
		end
	end

	always_ff @(posedge clk) begin
		behind_s6 <= side_v[33];
		if (diff_u > DLIM) begin
			du_s6 <= DIFF_W'(DLIM);
		end else if (diff_u < -DLIM) begin
			du_s6 <= DIFF_W'(-DLIM);
		end else begin
			du_s6 <= DIFF_W'(diff_u);
		end
		if (diff_v > DLIM) begin
			dv_s6 <= DIFF_W'(DLIM);
		end else if (diff_v < -DLIM) begin
			dv_s6 <= DIFF_W'(-DLIM);
		end else begin
			dv_s6 <= DIFF_W'(diff_v);
		end
	end

	// stage 7: squares
	logic        valid_s7, behind_s7;
	logic [56:0] sq_u_s7, sq_v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		behind_s7 <= behind_s6;
		sq_u_s7   <= 57'(du_s6) * 57'(du_s6);
		sq_v_s7   <= 57'(dv_s6) * 57'(dv_s6);
	end

	// stage 8: sum, threshold test, saturate into the result register
	logic [57:0] sum;

	assign sum = 58'(sq_u_s7) + 58'(sq_v_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (behind_s7) begin
			reject      <= 1'b1;
			cause       <= CAUSE_BEHIND;
			residual_sq <= '0;
		end else begin
			if (sum > {2'b00, thresh_q, 8'h00}) begin
				reject <= 1'b1;
				cause  <= CAUSE_FAR;
			end else begin
				reject <= 1'b0;
				cause  <= CAUSE_KEEP;
			end
			if (sum[57:56] != 2'b00) begin
				residual_sq <= RES_MAX;
			end else begin
				residual_sq <= sum[55:8];
			end
		end
	end

	// checks
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_u_valid == div_v_valid)
		else $error("divider lanes out of step");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result missing after pipeline latency");

	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && cause == CAUSE_BEHIND |-> reject && residual_sq == '0)
		else $error("behind-camera result malformed");

	a_keep_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done && !reject |-> cause == CAUSE_KEEP)
		else $error("kept result carries a cause");

endmodule
`default_nettype wire

// ----- hdl/rog_div.sv -----
`default_nettype none
module rog_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int SW = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic [NW-1:0]                  num,
	input  wire logic [DW-1:0]                  den,
	input  wire logic [SW-1:0]                  side,
	output logic                                out_valid,
	output logic [rog_pkg::PRED_BITS-1:0]       quo,
	output logic [SW-1:0]                       out_side
);
	import rog_pkg::*;

	localparam int QB = QUO_BITS;
	localparam int HW = NW - QB;
	localparam int XW = (HW > DW) ? HW : DW;

	logic          valid_s [0:QB];
	logic [DW-1:0] rem_s   [0:QB];
	logic [QB-1:0] low_s   [0:QB];
	logic [QB-1:0] q_s     [0:QB];
	logic [DW-1:0] den_s   [0:QB];
	logic          ovf_s   [0:QB];
	logic [SW-1:0] side_s  [0:QB];

	logic ovf_in;

	// quotient overflows 2^QB when the high numerator part reaches the divisor
	assign ovf_in = XW'(num[NW-1:QB]) >= XW'(den);

	// load stage: remainder seeded with the high numerator part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= DW'(num[NW-1:QB]);
		low_s[0]  <= num[QB-1:0];
		q_s[0]    <= '0;
		den_s[0]  <= den;
		ovf_s[0]  <= ovf_in;
		side_s[0] <= side;
	end

	// one restoring step per stage
	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[k-1], low_s[k-1][QB-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ge) begin
				rem_s[k] <= DW'(trial - {1'b0, den_s[k-1]});
			end else begin
				rem_s[k] <= DW'(trial);
			end
			low_s[k]  <= {low_s[k-1][QB-2:0], 1'b0};
			q_s[k]    <= {q_s[k-1][QB-2:0], ge};
			den_s[k]  <= den_s[k-1];
			ovf_s[k]  <= ovf_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	// clamp the quotient
	always_comb begin
		if (ovf_s[QB] || (q_s[QB] > QB'(PRED_LIMIT))) begin
			quo = PRED_LIMIT;
		end else begin
			quo = q_s[QB][PRED_BITS-1:0];
		end
	end

	assign out_valid = valid_s[QB];
	assign out_side  = side_s[QB];

endmodule
`default_nettype wire
